[hdl/jittered_cell_bump_stamper_top_defines.svh]
// jittered_cell_bump_stamper_top_defines.svh
// Assertion macros for the bump stamper top level; no dependencies.
`ifndef JITTERED_CELL_BUMP_STAMPER_TOP_DEFINES_SVH
`define JITTERED_CELL_BUMP_STAMPER_TOP_DEFINES_SVH
// same-cycle implication
`define JCBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jcbs assertion failed");
// next-cycle implication
`define JCBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jcbs assertion failed");
`endif

[hdl/jcbs_pkg.sv]
// jcbs_pkg.sv
// Types, constants and helpers of the jittered cell bump stamper.
// No dependencies.
package jcbs_pkg;

   localparam int PIX_BITS     = 12;
   localparam int COORD_BITS   = 12;
   localparam int QX_BITS      = COORD_BITS - 1;
   localparam int REM_SHIFT    = 17 - COORD_BITS;
   localparam int CELL_BITS    = 29;
   localparam int REM_BITS     = CELL_BITS;
   localparam int GAIN_BITS    = 31;
   localparam int SJ_BITS      = 17;
   localparam int FRAC_BITS    = 24;
   localparam int F_BITS       = 25;
   localparam int R_BITS       = 28;
   localparam int ABS_BITS     = 30;
   localparam int SQ_BITS      = 2 * ABS_BITS;
   localparam int SUM_BITS     = SQ_BITS + 1;
   localparam int SQ_STEPS     = 31;
   localparam int ROOT_BITS    = SQ_STEPS;
   localparam int SREM_BITS    = ROOT_BITS + 2;
   localparam int DQ_BITS      = 16;
   localparam int HX_BITS      = (COORD_BITS > 13 ? COORD_BITS : 13) + 1;
   localparam int NUM_LANES    = 9;
   localparam int HASH_STAGES  = 7;
   localparam int PROF_STAGES  = 4;
   localparam int LANE_LAT     = HASH_STAGES + SQ_STEPS + DQ_BITS + PROF_STAGES;

   localparam logic [CELL_BITS-1:0] MIN_CELL     = 29'd131072;
   localparam logic [CELL_BITS-1:0] CELL_RESET   = 29'd559241;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 31'd1311;
   localparam logic [SJ_BITS-1:0]   SJ_MAX       = 17'd65536;
   localparam logic [SJ_BITS-1:0]   SJ_RESET     = 17'd39322;
   localparam logic [16:0]          ONE_Q16      = 17'd65536;
   localparam logic [R_BITS-1:0]    ONE_R        = 28'd65536;
   localparam logic [F_BITS-1:0]    ONE_F        = 25'h1000000;
   localparam logic [HX_BITS-1:0]   CELL_BIAS_M1 = HX_BITS'(4095);
   localparam logic [31:0]          HASH_KA      = 32'h8da6b343;
   localparam logic [31:0]          HASH_KB      = 32'hd8163841;
   localparam logic [31:0]          HASH_KC      = 32'hcb1ab31f;
   localparam logic [31:0]          HASH_KD      = 32'h5bd1e995;
   localparam logic [FRAC_BITS-1:0] JY_MUL       = 24'd7;
   localparam logic [FRAC_BITS-1:0] JY_ADD       = 24'd1;
   localparam logic [FRAC_BITS-1:0] JU_MUL       = 24'd13;
   localparam logic [FRAC_BITS-1:0] JU_ADD       = 24'd5;

   typedef enum logic [2:0] {
      CSR_CELL_SIZE   = 3'd0,
      CSR_BUMP_GAIN   = 3'd1,
      CSR_SIZE_JITTER = 3'd2,
      CSR_POINTED     = 3'd3,
      CSR_HASH_SEED   = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      OFS_NEG = 2'd0,
      OFS_MID = 2'd1,
      OFS_POS = 2'd2
   } ofs_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] cell_size;
      logic [SJ_BITS-1:0]   jitter;
      logic [GAIN_BITS-1:0] gain;
      logic                 pointed;
      logic [31:0]          seed_mul;
   } lane_cfg_type;

   typedef struct packed {
      logic [QX_BITS-1:0]  cx;
      logic [QX_BITS-1:0]  cy;
      logic [REM_BITS-1:0] rx;
      logic [REM_BITS-1:0] ry;
   } lane_in_type;

   typedef struct packed {
      ofs_type ox;
      ofs_type oy;
   } lane_ofs_type;

   function automatic logic [GAIN_BITS-1:0] max3(input logic [GAIN_BITS-1:0] a,
                                                 input logic [GAIN_BITS-1:0] b,
                                                 input logic [GAIN_BITS-1:0] c);
      logic [GAIN_BITS-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage

[hdl/jcbs_bump_lane.sv]
// jcbs_bump_lane.sv
// One neighbour cell: hash, jittered centre, distance root, profile, contribution.
// Depends on jcbs_pkg.
module jcbs_bump_lane (
   input  logic                           clock,
   input  logic                           en,
   input  jcbs_pkg::lane_cfg_type         cfg,
   input  jcbs_pkg::lane_ofs_type         ofs,
   input  jcbs_pkg::lane_in_type          lin,
   output logic [jcbs_pkg::GAIN_BITS-1:0] add_out
);
   import jcbs_pkg::*;

   // hash stages
   logic [HX_BITS-1:0]   hx, hy;
   logic [31:0]          h1_in, h1_ff, h2_in, h2_ff, hv, v1;
   logic [REM_BITS-1:0]  rx1_ff, ry1_ff, rx2_ff, ry2_ff, rx3_ff, ry3_ff, rx4_ff, ry4_ff;
   logic [FRAC_BITS-1:0] jx3_in, jy3_in, u3_in, jx3_ff, jy3_ff, u3_ff;
   logic [SJ_BITS+FRAC_BITS-1:0]   sju;
   logic [CELL_BITS+FRAC_BITS-1:0] pjx, pjy;
   logic [F_BITS-1:0]    f4_in, f4_ff, f5_ff, f6_ff, f7_ff;
   logic [CELL_BITS-1:0] jxc4_in, jyc4_in, jxc4_ff, jyc4_ff;
   logic [CELL_BITS+F_BITS-1:0] cf;
   logic [R_BITS-1:0]    sz, r5_in, r5_ff, r6_ff, r7_ff;
   logic signed [31:0]   bx, by, dx, dy;
   logic [ABS_BITS-1:0]  adx5_in, ady5_in, adx5_ff, ady5_ff;
   logic [SQ_BITS-1:0]   sqx6_ff, sqy6_ff;
   logic [SUM_BITS-1:0]  sum7_ff;

   always_comb begin
      hx    = HX_BITS'(lin.cx) + CELL_BIAS_M1 + HX_BITS'(ofs.ox);
      hy    = HX_BITS'(lin.cy) + CELL_BIAS_M1 + HX_BITS'(ofs.oy);
      h1_in = 32'(32'(hx) * HASH_KA) ^ 32'(32'(hy) * HASH_KB) ^ cfg.seed_mul;
      v1    = h1_ff ^ (h1_ff >> 13);
      h2_in = 32'(v1 * HASH_KD);
      hv    = h2_ff ^ (h2_ff >> 15);
      jx3_in = hv[FRAC_BITS-1:0];
      jy3_in = FRAC_BITS'(hv[FRAC_BITS-1:0] * JY_MUL + JY_ADD);
      u3_in  = FRAC_BITS'(hv[FRAC_BITS-1:0] * JU_MUL + JU_ADD);
      sju    = (SJ_BITS+FRAC_BITS)'(cfg.jitter) * (SJ_BITS+FRAC_BITS)'(u3_ff);
      f4_in  = ONE_F - F_BITS'(sju >> 16);
      pjx    = (CELL_BITS+FRAC_BITS)'(jx3_ff) * (CELL_BITS+FRAC_BITS)'(cfg.cell_size);
      pjy    = (CELL_BITS+FRAC_BITS)'(jy3_ff) * (CELL_BITS+FRAC_BITS)'(cfg.cell_size);
      jxc4_in = CELL_BITS'(pjx >> FRAC_BITS);
      jyc4_in = CELL_BITS'(pjy >> FRAC_BITS);
      cf     = (CELL_BITS+F_BITS)'(cfg.cell_size) * (CELL_BITS+F_BITS)'(f4_ff);
      sz     = R_BITS'(cf >> F_BITS);
      r5_in  = (sz < ONE_R) ? ONE_R : sz;
      unique case (ofs.ox)
         OFS_NEG: bx = $signed(32'(rx4_ff)) + $signed(32'(cfg.cell_size));
         OFS_POS: bx = $signed(32'(rx4_ff)) - $signed(32'(cfg.cell_size));
         default: bx = $signed(32'(rx4_ff));
      endcase
      unique case (ofs.oy)
         OFS_NEG: by = $signed(32'(ry4_ff)) + $signed(32'(cfg.cell_size));
         OFS_POS: by = $signed(32'(ry4_ff)) - $signed(32'(cfg.cell_size));
         default: by = $signed(32'(ry4_ff));
      endcase
      dx = bx - $signed(32'(jxc4_ff));
      dy = by - $signed(32'(jyc4_ff));
      adx5_in = ABS_BITS'(dx[31] ? -dx : dx);
      ady5_in = ABS_BITS'(dy[31] ? -dy : dy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff   <= h1_in;
         rx1_ff  <= lin.rx;
         ry1_ff  <= lin.ry;
         h2_ff   <= h2_in;
         rx2_ff  <= rx1_ff;
         ry2_ff  <= ry1_ff;
         jx3_ff  <= jx3_in;
         jy3_ff  <= jy3_in;
         u3_ff   <= u3_in;
         rx3_ff  <= rx2_ff;
         ry3_ff  <= ry2_ff;
         f4_ff   <= f4_in;
         jxc4_ff <= jxc4_in;
         jyc4_ff <= jyc4_in;
         rx4_ff  <= rx3_ff;
         ry4_ff  <= ry3_ff;
         r5_ff   <= r5_in;
         f5_ff   <= f4_ff;
         adx5_ff <= adx5_in;
         ady5_ff <= ady5_in;
         sqx6_ff <= SQ_BITS'(adx5_ff) * SQ_BITS'(adx5_ff);
         sqy6_ff <= SQ_BITS'(ady5_ff) * SQ_BITS'(ady5_ff);
         r6_ff   <= r5_ff;
         f6_ff   <= f5_ff;
         sum7_ff <= SUM_BITS'(sqx6_ff) + SUM_BITS'(sqy6_ff);
         r7_ff   <= r6_ff;
         f7_ff   <= f6_ff;
      end
   end

   // square root, one result bit per stage
   logic [SREM_BITS-1:0]  sq_rem_ff  [SQ_STEPS];
   logic [ROOT_BITS-1:0]  sq_root_ff [SQ_STEPS];
   logic [2*SQ_STEPS-1:0] sq_v_ff    [SQ_STEPS];
   logic [R_BITS-1:0]     sq_r_ff    [SQ_STEPS];
   logic [F_BITS-1:0]     sq_f_ff    [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [SREM_BITS-1:0]  rem_prev, rem_in;
      logic [ROOT_BITS-1:0]  root_prev, root_in;
      logic [2*SQ_STEPS-1:0] v_prev;
      logic [R_BITS-1:0]     r_prev;
      logic [F_BITS-1:0]     f_prev;
      logic [SREM_BITS+1:0]  t, trial;
      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign v_prev    = (2*SQ_STEPS)'(sum7_ff);
         assign r_prev    = r7_ff;
         assign f_prev    = f7_ff;
      end else begin : g_next
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
         assign v_prev    = sq_v_ff[k-1];
         assign r_prev    = sq_r_ff[k-1];
         assign f_prev    = sq_f_ff[k-1];
      end
      always_comb begin
         t     = {rem_prev, v_prev[2*(SQ_STEPS-1-k)+1 -: 2]};
         trial = (SREM_BITS+2)'({root_prev, 2'b01});
         if (t >= trial) begin
            rem_in  = SREM_BITS'(t - trial);
            root_in = {root_prev[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = SREM_BITS'(t);
            root_in = {root_prev[ROOT_BITS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
            sq_v_ff[k]    <= v_prev;
            sq_r_ff[k]    <= r_prev;
            sq_f_ff[k]    <= f_prev;
         end
      end
   end

   // normalized distance, one quotient bit per stage
   logic [R_BITS-1:0]  dv_rem_ff [DQ_BITS];
   logic [DQ_BITS-1:0] dv_q_ff   [DQ_BITS];
   logic [R_BITS-1:0]  dv_r_ff   [DQ_BITS];
   logic [F_BITS-1:0]  dv_f_ff   [DQ_BITS];
   logic               dv_hit_ff [DQ_BITS];

   for (genvar k = 0; k < DQ_BITS; k++) begin : g_div
      logic [R_BITS-1:0]  rem_prev, rem_in, r_prev;
      logic [DQ_BITS-1:0] q_prev;
      logic [F_BITS-1:0]  f_prev;
      logic               hit_prev, qbit;
      logic [R_BITS:0]    t;
      if (k == 0) begin : g_first
         assign hit_prev = sq_root_ff[SQ_STEPS-1] < ROOT_BITS'(sq_r_ff[SQ_STEPS-1]);
         assign rem_prev = hit_prev ? sq_root_ff[SQ_STEPS-1][R_BITS-1:0] : '0;
         assign q_prev   = '0;
         assign r_prev   = sq_r_ff[SQ_STEPS-1];
         assign f_prev   = sq_f_ff[SQ_STEPS-1];
      end else begin : g_next
         assign hit_prev = dv_hit_ff[k-1];
         assign rem_prev = dv_rem_ff[k-1];
         assign q_prev   = dv_q_ff[k-1];
         assign r_prev   = dv_r_ff[k-1];
         assign f_prev   = dv_f_ff[k-1];
      end
      always_comb begin
         t    = {rem_prev, 1'b0};
         qbit = t >= (R_BITS+1)'(r_prev);
         rem_in = qbit ? R_BITS'(t - (R_BITS+1)'(r_prev)) : R_BITS'(t);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[k] <= rem_in;
            dv_q_ff[k]   <= {q_prev[DQ_BITS-2:0], qbit};
            dv_r_ff[k]   <= r_prev;
            dv_f_ff[k]   <= f_prev;
            dv_hit_ff[k] <= hit_prev;
         end
      end
   end

   // profile and contribution
   logic [DQ_BITS-1:0]   d1_ff;
   logic [2*DQ_BITS-1:0] sqd1_ff;
   logic [F_BITS-1:0]    f1_ff, f2_ff, f3_ff;
   logic                 hit1_ff, hit2_ff, hit3_ff;
   logic [16:0]          e2, p2_in, p2_ff;
   logic [33:0]          ee2;
   logic [16+GAIN_BITS:0] pgp;
   logic [GAIN_BITS-1:0] pg3_ff, add4_in, add_ff;
   logic [GAIN_BITS+F_BITS-1:0] pf;

   always_comb begin
      e2    = ONE_Q16 - 17'(sqd1_ff[2*DQ_BITS-1:DQ_BITS]);
      ee2   = 34'(e2) * 34'(e2);
      p2_in = cfg.pointed ? (ONE_Q16 - 17'(d1_ff)) : 17'(ee2 >> 16);
      pgp   = (17+GAIN_BITS)'(p2_ff) * (17+GAIN_BITS)'(cfg.gain);
      pf    = (GAIN_BITS+F_BITS)'(pg3_ff) * (GAIN_BITS+F_BITS)'(f3_ff);
      add4_in = hit3_ff ? GAIN_BITS'(pf >> FRAC_BITS) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff   <= dv_q_ff[DQ_BITS-1];
         sqd1_ff <= (2*DQ_BITS)'(dv_q_ff[DQ_BITS-1]) * (2*DQ_BITS)'(dv_q_ff[DQ_BITS-1]);
         f1_ff   <= dv_f_ff[DQ_BITS-1];
         hit1_ff <= dv_hit_ff[DQ_BITS-1];
         p2_ff   <= p2_in;
         f2_ff   <= f1_ff;
         hit2_ff <= hit1_ff;
         pg3_ff  <= GAIN_BITS'(pgp >> 16);
         f3_ff   <= f2_ff;
         hit3_ff <= hit2_ff;
         add_ff  <= add4_in;
      end
   end

   assign add_out = add_ff;

endmodule

[hdl/jittered_cell_bump_stamper_top.sv]
// Jittered cell bump stamper: adds the strongest of nine hashed bumps to a texel height.
// The request, response and CSR ports all run on one clock with a synchronous reset.
// The lane datapath comes from jcbs_bump_lane; the width settings and lane count come from jcbs_pkg.
// Usage:
//   req_* carries one texel (column, row, Q16.16 height). A transaction happens when
//   req_valid is high and req_stall is low. rsp_* returns one saturated height for each
//   texel, in order. The CSR writes (csr_valid & csr_ready, csr_ready is always high) set cell
//   size, gain, size jitter, shape and seed; the user writes them only while the block is idle (not enforced).
// Pipeline: 1 input stage, 11 stages of one-bit-per-stage cell division, 58 lane stages
// (hash 7, a 31-stage square root, a 16-stage distance divide, profile 4) and 3 stages
// for the max tree and saturation. One texel can enter on every cycle while the response
// is not held off.
// Stall: req_stall = rsp_valid & rsp_stall. The whole pipeline holds while the response
// is held off, and nothing is lost or repeated.
// Reset: the pipeline empties, and the configuration registers go back to their defaults.
`include "jittered_cell_bump_stamper_top_defines.svh"
module jittered_cell_bump_stamper_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [jcbs_pkg::PIX_BITS-1:0] req_pixel_x,
   input  logic [jcbs_pkg::PIX_BITS-1:0] req_pixel_y,
   input  logic signed [31:0]            req_height_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_height_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_data
);
   import jcbs_pkg::*;

   logic en;

   // configuration, stored already clamped
   logic [CELL_BITS-1:0] cell_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   logic [SJ_BITS-1:0]   jit_ff;
   logic                 pointed_ff;
   logic [31:0]          seed_mul_ff;
   logic [CELL_BITS-1:0] cell_wr;
   logic [SJ_BITS-1:0]   jit_wr;
   lane_cfg_type         lane_cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      cell_wr = (csr_data[CELL_BITS-1:0] < MIN_CELL) ? MIN_CELL : csr_data[CELL_BITS-1:0];
      jit_wr  = (csr_data[SJ_BITS-1:0] > SJ_MAX) ? SJ_MAX : csr_data[SJ_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff     <= CELL_RESET;
         gain_ff     <= GAIN_RESET;
         jit_ff      <= SJ_RESET;
         pointed_ff  <= 1'b0;
         seed_mul_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELL_SIZE:   cell_ff     <= cell_wr;
            CSR_BUMP_GAIN:   gain_ff     <= csr_data[GAIN_BITS-1:0];
            CSR_SIZE_JITTER: jit_ff      <= jit_wr;
            CSR_POINTED:     pointed_ff  <= csr_data[0];
            CSR_HASH_SEED:   seed_mul_ff <= 32'(csr_data * HASH_KC);
            default: ;
         endcase
      end
   end

   assign lane_cfg = '{cell_size: cell_ff, jitter: jit_ff, gain: gain_ff,
                       pointed: pointed_ff, seed_mul: seed_mul_ff};

   // pipeline advance
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // input stage
   logic                  in_v_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic signed [31:0]    h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= COORD_BITS'(req_pixel_x);
         y_ff <= COORD_BITS'(req_pixel_y);
         h_ff <= req_height_in;
      end
   end

   // cell index: restoring division by the cell size, one bit per stage
   logic                dq_v_ff  [QX_BITS];
   logic signed [31:0]  dq_h_ff  [QX_BITS];
   logic [QX_BITS-1:0]  dq_qx_ff [QX_BITS];
   logic [QX_BITS-1:0]  dq_qy_ff [QX_BITS];
   logic [REM_BITS-1:0] dq_rx_ff [QX_BITS];
   logic [REM_BITS-1:0] dq_ry_ff [QX_BITS];

   for (genvar k = 0; k < QX_BITS; k++) begin : g_cdiv
      logic                v_prev, bx, by;
      logic signed [31:0]  h_prev;
      logic [QX_BITS-1:0]  qx_prev, qy_prev;
      logic [REM_BITS-1:0] rx_prev, ry_prev, rx_in, ry_in;
      logic [REM_BITS:0]   tx, ty;
      if (k == 0) begin : g_first
         assign v_prev  = in_v_ff;
         assign h_prev  = h_ff;
         assign qx_prev = '0;
         assign qy_prev = '0;
         assign rx_prev = REM_BITS'(x_ff) << REM_SHIFT;
         assign ry_prev = REM_BITS'(y_ff) << REM_SHIFT;
      end else begin : g_next
         assign v_prev  = dq_v_ff[k-1];
         assign h_prev  = dq_h_ff[k-1];
         assign qx_prev = dq_qx_ff[k-1];
         assign qy_prev = dq_qy_ff[k-1];
         assign rx_prev = dq_rx_ff[k-1];
         assign ry_prev = dq_ry_ff[k-1];
      end
      always_comb begin
         tx    = {rx_prev, 1'b0};
         ty    = {ry_prev, 1'b0};
         bx    = tx >= (REM_BITS+1)'(cell_ff);
         by    = ty >= (REM_BITS+1)'(cell_ff);
         rx_in = bx ? REM_BITS'(tx - (REM_BITS+1)'(cell_ff)) : REM_BITS'(tx);
         ry_in = by ? REM_BITS'(ty - (REM_BITS+1)'(cell_ff)) : REM_BITS'(ty);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dq_v_ff[k] <= 1'b0;
         end else if (en) begin
            dq_v_ff[k] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dq_h_ff[k]  <= h_prev;
            dq_qx_ff[k] <= {qx_prev[QX_BITS-2:0], bx};
            dq_qy_ff[k] <= {qy_prev[QX_BITS-2:0], by};
            dq_rx_ff[k] <= rx_in;
            dq_ry_ff[k] <= ry_in;
         end
      end
   end

   // nine neighbour lanes
   lane_in_type          lane_in;
   logic [GAIN_BITS-1:0] lane_add [NUM_LANES];

   assign lane_in = '{cx: dq_qx_ff[QX_BITS-1], cy: dq_qy_ff[QX_BITS-1],
                      rx: dq_rx_ff[QX_BITS-1], ry: dq_ry_ff[QX_BITS-1]};

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      lane_ofs_type ofs;
      assign ofs = '{ox: ofs_type'(2'(g % 3)), oy: ofs_type'(2'(g / 3))};
      jcbs_bump_lane u_lane (
         .clock   (clock),
         .en      (en),
         .cfg     (lane_cfg),
         .ofs     (ofs),
         .lin     (lane_in),
         .add_out (lane_add[g])
      );
   end

   // valid and height ride alongside the lanes
   logic               lv_ff [LANE_LAT];
   logic signed [31:0] lh_ff [LANE_LAT];

   for (genvar k = 0; k < LANE_LAT; k++) begin : g_dly
      logic               v_prev;
      logic signed [31:0] h_prev;
      if (k == 0) begin : g_first
         assign v_prev = dq_v_ff[QX_BITS-1];
         assign h_prev = dq_h_ff[QX_BITS-1];
      end else begin : g_next
         assign v_prev = lv_ff[k-1];
         assign h_prev = lh_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[k] <= 1'b0;
         end else if (en) begin
            lv_ff[k] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            lh_ff[k] <= h_prev;
         end
      end
   end

   // max tree and saturating add
   logic [GAIN_BITS-1:0] m1_ff [3];
   logic                 m1_v_ff, m2_v_ff;
   logic signed [31:0]   m1_h_ff, m2_h_ff;
   logic [GAIN_BITS-1:0] m2_best_ff;
   logic signed [32:0]   sum;
   logic signed [31:0]   height_in, height_ff;

   always_comb begin
      sum = $signed({m2_h_ff[31], m2_h_ff}) + $signed(33'(m2_best_ff));
      height_in = (sum > 33'sd2147483647) ? 32'sh7fffffff : sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff      <= 1'b0;
         m2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff      <= lv_ff[LANE_LAT-1];
         m2_v_ff      <= m1_v_ff;
         rsp_valid_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff[0]   <= max3(lane_add[0], lane_add[1], lane_add[2]);
         m1_ff[1]   <= max3(lane_add[3], lane_add[4], lane_add[5]);
         m1_ff[2]   <= max3(lane_add[6], lane_add[7], lane_add[8]);
         m1_h_ff    <= lh_ff[LANE_LAT-1];
         m2_best_ff <= max3(m1_ff[0], m1_ff[1], m1_ff[2]);
         m2_h_ff    <= m1_h_ff;
         height_ff  <= height_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = height_ff;

   `JCBS_ASSERT_NXT(a_no_height_drop, clock, reset, en && m2_v_ff, rsp_height_out >= $past(m2_h_ff))
   `JCBS_ASSERT_NXT(a_tail_moves, clock, reset, en && m2_v_ff, rsp_valid)
   `JCBS_ASSERT_IMP(a_reset_empty, clock, reset, $fell(reset), !rsp_valid && !m2_v_ff && !in_v_ff)

endmodule

[bench/tb_top.sv]
// tb_top.sv
// Self-checking bench for jittered_cell_bump_stamper_top: directed, random and backpressure tests
// against a built-in bump height predictor. Depends on jcbs_pkg and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import jcbs_pkg::*;

   localparam logic [2:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [PIX_BITS-1:0] req_pixel_x = '0;
   logic [PIX_BITS-1:0] req_pixel_y = '0;
   logic signed [31:0] req_height_in = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_height_out;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor copy of the register file
   logic [28:0] cfg_cell;
   logic [30:0] cfg_gain;
   logic [16:0] cfg_jitter;
   logic cfg_pointed;
   logic [31:0] cfg_seed;

   logic signed [31:0] height_expq[$];
   int errors = 0;
   int quiet_cycles = 0;
   bit send_idle_on = 1;
   bit rsp_idle_on = 1;
   bit hold_req = 0;

   jittered_cell_bump_stamper_top dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] cell_hash(logic [31:0] a, logic [31:0] b, logic [31:0] s);
      logic [31:0] v;
      v = (a * HASH_KA) ^ (b * HASH_KB) ^ (s * HASH_KC);
      v ^= v >> 13;
      v = v * HASH_KD;
      v ^= v >> 15;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] bumped_height(logic [11:0] px_in, logic [11:0] py_in,
                                                        logic signed [31:0] hin);
      longint unsigned c, sj, cx, cy, jx, jy, u, f, sz, r, adx, ady, dist_q, d, p, e, add, best;
      longint xq, yq, cpx, cpy, dx, dy, sum;
      logic [31:0] hv, hx, hy;
      c = (cfg_cell < MIN_CELL) ? MIN_CELL : cfg_cell;
      sj = (cfg_jitter > SJ_MAX) ? SJ_MAX : cfg_jitter;
      xq = longint'(px_in) << 16;
      yq = longint'(py_in) << 16;
      cx = (longint'(px_in) << 16) / c;
      cy = (longint'(py_in) << 16) / c;
      best = 0;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            hx = 32'(cx + 4096 + i - 1);
            hy = 32'(cy + 4096 + j - 1);
            hv = cell_hash(hx, hy, cfg_seed);
            jx = 64'(hv & 32'hffffff);
            jy = 64'(32'(hv * 32'd7 + 32'd1) & 32'hffffff);
            u = 64'(32'(hv * 32'd13 + 32'd5) & 32'hffffff);
            f = (64'd1 << 24) - ((sj * u) >> 16);
            sz = (c * f) >> 25;
            r = (sz < 65536) ? 65536 : sz;
            cpx = (longint'(cx) + i - 1) * longint'(c) + longint'((jx * c) >> 24);
            cpy = (longint'(cy) + j - 1) * longint'(c) + longint'((jy * c) >> 24);
            dx = xq - cpx;
            dy = yq - cpy;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            dist_q = int_sqrt(adx * adx + ady * ady);
            if (dist_q < r) begin
               d = (dist_q << 16) / r;
               if (cfg_pointed) begin
                  p = 65536 - d;
               end else begin
                  e = 65536 - ((d * d) >> 16);
                  p = (e * e) >> 16;
               end
               add = (((p * cfg_gain) >> 16) * f) >> 24;
               if (add > best) best = add;
            end
         end
      end
      sum = longint'(hin) + longint'(best);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      return sum[31:0];
   endfunction

   task automatic send_texel(logic [11:0] x, logic [11:0] y, logic signed [31:0] h);
      int gap;
      gap = send_idle_on ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12)) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_height_in <= h;
      do @(posedge clock); while (!(req_valid && !req_stall));
      height_expq.push_back(bumped_height(x, y, h));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 0;
      while (height_expq.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CELL_SIZE:   cfg_cell = data[28:0];
         CSR_BUMP_GAIN:   cfg_gain = data[30:0];
         CSR_SIZE_JITTER: cfg_jitter = data[16:0];
         CSR_POINTED:     cfg_pointed = data[0];
         CSR_HASH_SEED:   cfg_seed = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_config(logic [31:0] cell_v, logic [31:0] gain, logic [31:0] jit,
                             logic pointed, logic [31:0] seed);
      wait_idle();
      write_csr(CSR_CELL_SIZE, cell_v);
      write_csr(CSR_BUMP_GAIN, gain);
      write_csr(CSR_SIZE_JITTER, jit);
      write_csr(CSR_POINTED, {31'd0, pointed});
      write_csr(CSR_HASH_SEED, seed);
   endtask

   task automatic test_reset_defaults();
      send_texel(12'd0, 12'd0, 32'sd0);
      send_texel(12'hfff, 12'hfff, 32'h7fffffff);
      send_texel(12'hfff, 12'd0, 32'h80000000);
      send_texel(12'd0, 12'hfff, -32'sd1);
      send_texel(12'haaa, 12'h555, 32'h55555555);
      send_texel(12'h555, 12'haaa, 32'haaaaaaaa);
   endtask

   task automatic test_clamps_and_shapes();
      // cell below 2.0 and jitter above 1.0 both clamp; huge gain saturates
      set_config(32'd0, 32'h7fffffff, 32'h1ffff, 1'b1, 32'hffffffff);
      for (int k = 0; k < 4; k++) send_texel(12'(k), 12'(k * 3), 32'h7ffffff0);
      wait_idle();
      write_csr(CSR_POINTED, 32'd0);
      for (int k = 0; k < 3; k++) send_texel(12'(k * 5), 12'(k), 32'h7fff0000);
      set_config(32'h1fffffff, 32'h7fffffff, 32'd0, 1'b1, 32'd12345);
      send_texel(12'hfff, 12'hfff, 32'sd0);
      send_texel(12'd800, 12'd1900, -32'sd100000);
      set_config(32'd131072, 32'd0, 32'd65536, 1'b0, 32'd7);
      send_texel(12'd3, 12'd9, 32'sd424242);
      send_texel(12'hfff, 12'd1, 32'h80000000);
   endtask

   task automatic test_unknown_index();
      wait_idle();
      write_csr(CSR_UNUSED_LO, 32'hffffffff);
      write_csr(CSR_UNUSED_HI, 32'h0);
      send_texel(12'd17, 12'd33, 32'sd65536);
   endtask

   task automatic test_random();
      logic [31:0] cell_v, gain, jit, h;
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0: cell_v = $urandom_range(131072, 1 << 22);
            1: cell_v = $urandom_range(0, 131071);
            2: cell_v = $urandom_range(1 << 22, 268435456);
            default: cell_v = $urandom;
         endcase
         gain = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1 << 20) : $urandom;
         jit = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536);
         set_config(cell_v, gain, jit, 1'($urandom_range(0, 1)), $urandom);
         send_idle_on = (ph % 3) != 2;
         rsp_idle_on = (ph % 4) != 3;
         for (int k = 0; k < 80; k++) begin
            h = ($urandom_range(0, 4) == 0) ? (32'h7fffffff - $urandom_range(0, 1 << 24))
                                            : $urandom;
            send_texel(12'($urandom), 12'($urandom), h);
         end
      end
      send_idle_on = 1;
      rsp_idle_on = 1;
   endtask

   task automatic test_backpressure();
      wait_idle();
      send_idle_on = 0;
      hold_req = 1;
      for (int k = 0; k < 120; k++) send_texel(12'($urandom), 12'($urandom), $urandom);
      send_idle_on = 1;
   endtask

   initial begin
      cfg_cell = CELL_RESET;
      cfg_gain = GAIN_RESET;
      cfg_jitter = SJ_RESET;
      cfg_pointed = 0;
      cfg_seed = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_reset_defaults();
      test_clamps_and_shapes();
      test_unknown_index();
      test_random();
      test_backpressure();
      @(negedge clock);
      req_valid <= 0;
      while (height_expq.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      int n;
      forever begin
         if (hold_req) begin
            @(negedge clock);
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end
         n = rsp_idle_on ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12)) : 0;
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && !hold_req);
      end
   end

   logic signed [31:0] exp_height;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (height_expq.size() == 0) begin
            $error("height_out unexpected transaction, actual %0d", rsp_height_out);
            errors++;
         end else begin
            exp_height = height_expq.pop_front();
            if (exp_height !== rsp_height_out) begin
               $error("height_out expected %0d actual %0d", exp_height, rsp_height_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end
endmodule

[filelist.f]
+incdir+hdl
hdl/jcbs_pkg.sv
hdl/jcbs_bump_lane.sv
hdl/jittered_cell_bump_stamper_top.sv
bench/tb_top.sv
